FILE: rtl/drc_pkg.sv
package drc_pkg;

    localparam int unsigned DEFAULT_LIST_DEPTH = 32;
    localparam logic [15:0] RESET_MERGE_GAP = 16'd256;

    typedef enum logic [1:0] {
        ACT_MARK  = 2'd0,
        ACT_ALL   = 2'd1,
        ACT_FLUSH = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic {
        CFG_MERGE_GAP   = 1'b0,
        CFG_BUFFER_SIZE = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] range_start;
        logic [31:0] range_length;
    } in_item_t;

    typedef struct packed {
        logic [31:0] out_start;
        logic [32:0] out_length;
        logic        is_last;
        logic        overflowed;
    } out_item_t;

    // Order key: start ascending, then length descending.
    function automatic logic goes_before(input logic [31:0] s1, input logic [32:0] l1,
                                         input logic [31:0] s2, input logic [32:0] l2);
        if (s1 != s2)
        begin
            return s1 < s2;
        end
        return l1 > l2;
    endfunction

    // Length clipped so that start + length stays at or below 2^32.
    function automatic logic [32:0] clip_len(input logic [31:0] s, input logic [32:0] l);
        logic [32:0] room;
        room = 33'h1_0000_0000 - {1'b0, s};
        return (l > room) ? room : l;
    endfunction

endpackage

FILE: rtl/drc_list_mem.sv
module drc_list_mem #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW = 5
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [64:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [64:0]   rdata
);
    logic [64:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/dirty_range_coalescer.sv
// Channel   Direction  Handshake        Payload
// in        input      in_valid/stall   in_item_t (action, range_start, range_length)
// out       output     out_valid/stall  out_item_t (start, length, is_last, overflowed)
// cfg       input      cfg_we           cfg_index, cfg_data
// Marks and mark-alls finish in ST_IDLE; a mark on a full list with a nonzero buffer
// size also visits ST_APPEND, as the fallback and the new range need separate writes.
// A flush of n entries sorts by selection over the list memory: pass p reads n-p
// entries, then ST_SWAP moves the head entry into the slot of the minimum and ST_EMIT
// folds the minimum, so the flush holds the input until it is done, and ST_EMIT also
// waits while out_stall holds the previous result in the output register.
// Reset clears the count, the overflow flag, the output valid and the control state.
module dirty_range_coalescer #(
    parameter int unsigned LIST_DEPTH = drc_pkg::DEFAULT_LIST_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  drc_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output drc_pkg::out_item_t  out_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_data
);
    import drc_pkg::*;

    localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(LIST_DEPTH);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_SWAP   = 5'b00100,
        ST_EMIT   = 5'b01000,
        ST_APPEND = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic [15:0] gap_reg;
    logic [31:0] bsize_reg;
    logic [CW-1:0] count_reg, count_next;
    logic        ovf_reg, ovf_next;
    logic        ovf_snap_reg, ovf_snap_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic [CW-1:0] best_idx_reg, best_idx_next;
    logic [31:0] best_s_reg, best_s_next;
    logic [32:0] best_l_reg, best_l_next;
    logic        rd_pend_reg, rd_pend_next;
    logic        have_cur_reg, have_cur_next;
    logic [31:0] cs_reg, cs_next;
    logic [32:0] ce_reg, ce_next;
    logic        ov_reg, ov_next;
    out_item_t   ob_reg, ob_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [64:0]   wdata, rdata;
    logic [31:0]   rs;
    logic [32:0]   rl;
    logic          in_acc;

    drc_list_mem #(.DEPTH(LIST_DEPTH), .AW(AW)) u_mem (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign rs = rdata[64:33];
    assign rl = rdata[32:0];
    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc = in_valid && !in_stall;
    assign out_valid = ov_reg;
    assign out_data = ob_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            gap_reg <= RESET_MERGE_GAP;
            bsize_reg <= '0;
            count_reg <= '0;
            ovf_reg <= 1'b0;
            ov_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            have_cur_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg <= ovf_next;
            ov_reg <= ov_next;
            rd_pend_reg <= rd_pend_next;
            have_cur_reg <= have_cur_next;
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_MERGE_GAP:   gap_reg <= cfg_data[15:0];
                    CFG_BUFFER_SIZE: bsize_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ovf_snap_reg <= ovf_snap_next;
        n_reg <= n_next;
        pos_reg <= pos_next;
        scan_reg <= scan_next;
        best_idx_reg <= best_idx_next;
        best_s_reg <= best_s_next;
        best_l_reg <= best_l_next;
        cs_reg <= cs_next;
        ce_reg <= ce_next;
        ob_reg <= ob_next;
    end

    always_comb
    begin
        logic [32:0] gap_end;
        logic [32:0] ne;
        logic [32:0] new_len;
        state_next = state_reg;
        count_next = count_reg;
        ovf_next = ovf_reg;
        ovf_snap_next = ovf_snap_reg;
        n_next = n_reg;
        pos_next = pos_reg;
        scan_next = scan_reg;
        best_idx_next = best_idx_reg;
        best_s_next = best_s_reg;
        best_l_next = best_l_reg;
        rd_pend_next = 1'b0;
        have_cur_next = have_cur_reg;
        cs_next = cs_reg;
        ce_next = ce_reg;
        ov_next = ov_reg && out_stall;
        ob_next = ob_reg;
        we = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = scan_reg[AW-1:0];
        gap_end = ce_reg + {17'd0, gap_reg};
        ne = {1'b0, best_s_reg} + best_l_reg;
        new_len = clip_len(in_data.range_start, {1'b0, in_data.range_length});

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (action_t'(in_data.action))
                        ACT_MARK:
                        begin
                            if (in_data.range_length != '0)
                            begin
                                if (count_reg >= FULL)
                                begin
                                    ovf_next = 1'b1;
                                    we = 1'b1;
                                    waddr = '0;
                                    count_next = CW'(1);
                                    if (bsize_reg != '0)
                                    begin
                                        wdata = {32'd0, 1'b0, bsize_reg};
                                        best_s_next = in_data.range_start;
                                        best_l_next = new_len;
                                        state_next = ST_APPEND;
                                    end
                                    else
                                    begin
                                        wdata = {in_data.range_start, new_len};
                                    end
                                end
                                else
                                begin
                                    we = 1'b1;
                                    waddr = count_reg[AW-1:0];
                                    wdata = {in_data.range_start, new_len};
                                    count_next = count_reg + CW'(1);
                                end
                            end
                        end
                        ACT_ALL:
                        begin
                            count_next = '0;
                            if (bsize_reg != '0)
                            begin
                                we = 1'b1;
                                waddr = '0;
                                wdata = {32'd0, 1'b0, bsize_reg};
                                count_next = CW'(1);
                            end
                        end
                        ACT_FLUSH:
                        begin
                            ovf_snap_next = ovf_reg;
                            ovf_next = 1'b0;
                            n_next = count_reg;
                            count_next = '0;
                            have_cur_next = 1'b0;
                            pos_next = '0;
                            scan_next = '0;
                            if (count_reg != '0)
                            begin
                                state_next = ST_SCAN;
                                raddr = '0;
                                rd_pend_next = 1'b1;
                                scan_next = CW'(1);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_APPEND:
            begin
                we = 1'b1;
                waddr = count_reg[AW-1:0];
                wdata = {best_s_reg, best_l_reg};
                count_next = count_reg + CW'(1);
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                // The read of entry scan_reg-1 has completed and is on rdata.
                if (rd_pend_reg)
                begin
                    if (scan_reg - CW'(1) == pos_reg ||
                        goes_before(rs, rl, best_s_reg, best_l_reg))
                    begin
                        best_idx_next = scan_reg - CW'(1);
                        best_s_next = rs;
                        best_l_next = rl;
                    end
                end
                if (scan_reg < n_reg)
                begin
                    raddr = scan_reg[AW-1:0];
                    rd_pend_next = 1'b1;
                    scan_next = scan_reg + CW'(1);
                end
                else
                begin
                    raddr = pos_reg[AW-1:0];
                    state_next = ST_SWAP;
                end
            end
            ST_SWAP:
            begin
                // The entry at pos moves into the slot that the minimum leaves.
                we = 1'b1;
                waddr = best_idx_reg[AW-1:0];
                wdata = rdata;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    if (pos_reg == n_reg)
                    begin
                        ob_next.out_start = cs_reg;
                        ob_next.out_length = ce_reg - {1'b0, cs_reg};
                        ob_next.is_last = 1'b1;
                        ob_next.overflowed = ovf_snap_reg;
                        ov_next = 1'b1;
                        have_cur_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        if (have_cur_reg && {1'b0, best_s_reg} <= gap_end)
                        begin
                            if (ne > ce_reg)
                            begin
                                ce_next = ne;
                            end
                        end
                        else
                        begin
                            if (have_cur_reg)
                            begin
                                ob_next.out_start = cs_reg;
                                ob_next.out_length = ce_reg - {1'b0, cs_reg};
                                ob_next.is_last = 1'b0;
                                ob_next.overflowed = ovf_snap_reg;
                                ov_next = 1'b1;
                            end
                            cs_next = best_s_reg;
                            ce_next = ne;
                        end
                        have_cur_next = 1'b1;
                        pos_next = pos_reg + CW'(1);
                        if (pos_next != n_reg)
                        begin
                            raddr = pos_next[AW-1:0];
                            rd_pend_next = 1'b1;
                            scan_next = pos_reg + CW'(2);
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    property p_stall_busy;
        @(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall;
    endproperty
    a_stall_busy: assert property (p_stall_busy) else $error("input taken while busy");

    property p_count_bound;
        @(posedge clk) disable iff (!rst_n)
        count_reg <= FULL;
    endproperty
    a_count_bound: assert property (p_count_bound) else $error("entry count past depth");

    property p_flush_clears;
        @(posedge clk) disable iff (!rst_n)
        (in_acc && in_data.action == ACT_FLUSH) |=> (count_reg == '0 && !ovf_reg);
    endproperty
    a_flush_clears: assert property (p_flush_clears) else $error("flush left list state");

endmodule

FILE: dv/dirty_range_coalescer_test.sv
`timescale 1ns / 100ps

module dirty_range_coalescer_test;
    import drc_pkg::*;

    localparam int DEPTH = DEFAULT_LIST_DEPTH;
    localparam int IDLE_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_item_t in_data;
    logic out_valid;
    logic out_stall;
    out_item_t out_data;
    logic cfg_we;
    logic cfg_index;
    logic [31:0] cfg_data;

    dirty_range_coalescer DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    in_item_t pending_items[$];
    out_item_t expected_ranges[$];

    logic [15:0] gap_model;
    logic [31:0] size_model;
    logic [31:0] list_start[DEPTH];
    logic [32:0] list_len[DEPTH];
    int list_count;
    logic overflow_model;

    int send_idle_pct;
    int stall_pct;
    int errors;
    int idle_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    task automatic queue_item(in_item_t it);
        pending_items.insert(pending_items.size(), it);
    endtask

    function automatic logic [32:0] clipped(logic [31:0] s, logic [32:0] l);
        logic [32:0] room;
        room = 33'h1_0000_0000 - {1'b0, s};
        return (l > room) ? room : l;
    endfunction

    task automatic append_range(logic [31:0] s, logic [32:0] l);
        if (list_count < DEPTH)
        begin
            list_start[list_count] = s;
            list_len[list_count] = clipped(s, l);
            list_count++;
        end
    endtask

    task automatic reset_to_whole();
        list_count = 0;
        if (size_model != 0)
        begin
            append_range(32'd0, {1'b0, size_model});
        end
    endtask

    task automatic predict_ranges(in_item_t it);
        logic [31:0] ss[DEPTH];
        logic [32:0] ll[DEPTH];
        logic [31:0] ts;
        logic [32:0] tl;
        logic [32:0] cur_end;
        logic [32:0] nxt_end;
        logic [31:0] cur_start;
        logic ov;
        int n;
        int j;
        out_item_t r;
        case (action_t'(it.action))
            ACT_MARK:
            begin
                if (it.range_length != 0)
                begin
                    if (list_count >= DEPTH)
                    begin
                        reset_to_whole();
                        overflow_model = 1'b1;
                    end
                    append_range(it.range_start, {1'b0, it.range_length});
                end
            end
            ACT_ALL:
            begin
                reset_to_whole();
            end
            ACT_FLUSH:
            begin
                n = list_count;
                ov = overflow_model;
                list_count = 0;
                overflow_model = 1'b0;
                for (int i = 0; i < n; i++)
                begin
                    ts = list_start[i];
                    tl = list_len[i];
                    j = i;
                    while (j > 0 && (ts != ss[j-1] ? ts < ss[j-1] : tl > ll[j-1]))
                    begin
                        ss[j] = ss[j-1];
                        ll[j] = ll[j-1];
                        j--;
                    end
                    ss[j] = ts;
                    ll[j] = tl;
                end
                if (n > 0)
                begin
                    cur_start = ss[0];
                    cur_end = {1'b0, ss[0]} + ll[0];
                    for (int i = 1; i <= n; i++)
                    begin
                        if (i < n && {2'b0, ss[i]} <= {1'b0, cur_end} + {18'd0, gap_model})
                        begin
                            nxt_end = {1'b0, ss[i]} + ll[i];
                            if (nxt_end > cur_end)
                            begin
                                cur_end = nxt_end;
                            end
                        end
                        else
                        begin
                            r.out_start = cur_start;
                            r.out_length = cur_end - {1'b0, cur_start};
                            r.is_last = (i == n);
                            r.overflowed = ov;
                            expected_ranges.insert(expected_ranges.size(), r);
                            if (i < n)
                            begin
                                cur_start = ss[i];
                                cur_end = {1'b0, ss[i]} + ll[i];
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data <= pending_items.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_ranges(in_data);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_ranges.size() == 0)
                begin
                    $error("unexpected transaction start=%h", out_data.out_start);
                    errors++;
                end
                else
                begin
                    out_item_t e;
                    e = expected_ranges.pop_front();
                    if (out_data.out_start !== e.out_start)
                    begin
                        $error("out_start exp %h got %h", e.out_start, out_data.out_start);
                        errors++;
                    end
                    if (out_data.out_length !== e.out_length)
                    begin
                        $error("out_length exp %h got %h", e.out_length, out_data.out_length);
                        errors++;
                    end
                    if (out_data.is_last !== e.is_last)
                    begin
                        $error("is_last exp %b got %b", e.is_last, out_data.is_last);
                        errors++;
                    end
                    if (out_data.overflowed !== e.overflowed)
                    begin
                        $error("overflowed exp %b got %b", e.overflowed, out_data.overflowed);
                        errors++;
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("TB_ERROR");
                    $finish;
                end
            end
        end
    end

    function automatic in_item_t make_item(action_t a, logic [31:0] s, logic [31:0] l);
        in_item_t it;
        it.action = a;
        it.range_start = s;
        it.range_length = l;
        return it;
    endfunction

    task automatic write_reg(cfg_index_t idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MERGE_GAP)
        begin
            gap_model = val[15:0];
        end
        else
        begin
            size_model = val;
        end
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || in_valid || expected_ranges.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DEPTH * (DEPTH + 2) + 20) @(posedge clk);
    endtask

    function automatic in_item_t random_mark(logic [31:0] span);
        logic [31:0] s;
        logic [31:0] l;
        case ($urandom_range(9))
            0: s = $urandom();
            1: s = 32'hFFFF_FFFF - $urandom_range(2000);
            default: s = $urandom_range(span);
        endcase
        case ($urandom_range(9))
            0: l = $urandom();
            1: l = 32'd0;
            default: l = $urandom_range(300) + 1;
        endcase
        return make_item(ACT_MARK, s, l);
    endfunction

    task automatic queue_random(int count);
        int k;
        int burst;
        logic [31:0] span;
        k = 0;
        while (k < count)
        begin
            burst = ($urandom_range(7) == 0) ? $urandom_range(DEPTH + 6, DEPTH + 1)
                                              : $urandom_range(12, 1);
            span = ($urandom_range(1) == 0) ? 32'd4000 : 32'hFFFF_FFFF;
            if ($urandom_range(9) == 0)
            begin
                queue_item(make_item(ACT_ALL, $urandom(), $urandom()));
                k++;
            end
            for (int i = 0; i < burst && k < count; i++)
            begin
                queue_item(random_mark(span));
                k++;
            end
            if ($urandom_range(15) == 0)
            begin
                queue_item(make_item(ACT_NONE, $urandom(), $urandom()));
            end
            queue_item(make_item(ACT_FLUSH, $urandom(), $urandom()));
            k++;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_MERGE_GAP;
        cfg_data = '0;
        errors = 0;
        idle_cycles = 0;
        list_count = 0;
        overflow_model = 1'b0;
        gap_model = RESET_MERGE_GAP;
        size_model = 32'd0;
        send_idle_pct = 14;
        stall_pct = 63;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        queue_item(make_item(ACT_FLUSH, 32'd0, 32'd0));
        queue_item(make_item(ACT_MARK, 32'd100, 32'd0));
        queue_item(make_item(ACT_MARK, 32'd0, 32'd1));
        queue_item(make_item(ACT_MARK, 32'd257, 32'd10));
        queue_item(make_item(ACT_MARK, 32'd1000, 32'd5));
        queue_item(make_item(ACT_MARK, 32'd1000, 32'd50));
        queue_item(make_item(ACT_MARK, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        queue_item(make_item(ACT_MARK, 32'hFFFF_FF00, 32'h0000_0200));
        queue_item(make_item(ACT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        queue_item(make_item(ACT_FLUSH, 32'd0, 32'd0));
        queue_item(make_item(ACT_MARK, 32'd5, 32'd5));
        queue_item(make_item(ACT_ALL, 32'd0, 32'd0));
        queue_item(make_item(ACT_FLUSH, 32'd0, 32'd0));
        drain();

        write_reg(CFG_BUFFER_SIZE, 32'hFFFF_FFFF);
        write_reg(CFG_MERGE_GAP, 32'd0);
        queue_item(make_item(ACT_MARK, 32'd10, 32'd10));
        queue_item(make_item(ACT_MARK, 32'd20, 32'd10));
        queue_item(make_item(ACT_MARK, 32'd31, 32'd1));
        queue_item(make_item(ACT_FLUSH, 32'd0, 32'd0));
        queue_item(make_item(ACT_ALL, 32'd0, 32'd0));
        queue_item(make_item(ACT_MARK, 32'hFFFF_FFFF, 32'd1));
        queue_item(make_item(ACT_FLUSH, 32'd0, 32'd0));
        for (int i = 0; i < DEPTH + 1; i++)
        begin
            queue_item(make_item(ACT_MARK, 32'd4 * i, 32'd1));
        end
        queue_item(make_item(ACT_FLUSH, 32'd0, 32'd0));
        drain();

        write_reg(CFG_MERGE_GAP, 32'd65535);
        write_reg(CFG_BUFFER_SIZE, 32'd0);
        queue_random(30);
        drain();

        send_idle_pct = 63;
        stall_pct = 14;
        write_reg(CFG_MERGE_GAP, 32'd256);
        write_reg(CFG_BUFFER_SIZE, 32'd3000);
        queue_random(30);
        drain();

        send_idle_pct = 0;
        stall_pct = 0;
        write_reg(CFG_MERGE_GAP, 32'd3);
        write_reg(CFG_BUFFER_SIZE, 32'd70000);
        queue_random(40);
        drain();

        if (errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
